// ----- design/multiset_similarity_engine_defines.svh -----
// Assertion macros for the checker file.
`ifndef MULTISET_SIMILARITY_ENGINE_DEFINES_SVH
`define MULTISET_SIMILARITY_ENGINE_DEFINES_SVH

// Checked only while reset is released.
`define MSE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define MSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/msim_pkg.sv -----
package msim_pkg;

  typedef struct packed {
    logic [63:0] first_word;
    logic [63:0] second_word;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [16:0] similarity_q16;
    logic [8:0]  hamming_distance;
    logic        empty_denominator;
    logic        bad_method;
  } out_item_t;

  typedef struct packed {
    logic [15:0] min_total;
    logic [15:0] max_total;
    logic [15:0] first_total;
    logic [15:0] second_total;
    logic [23:0] dot_total;
    logic [23:0] first_norm_total;
    logic [23:0] second_norm_total;
    logic [8:0]  mismatch_total;
  } totals_t;

  typedef struct packed {
    logic       start;
    logic       sqrt_mode;
    logic [5:0] steps;
  } iter_ctl_t;

  localparam logic [2:0] METH_JACCARD = 3'd0;
  localparam logic [2:0] METH_COSINE  = 3'd1;
  localparam logic [2:0] METH_HAMMING = 3'd2;
  localparam logic [2:0] METH_DICE    = 3'd3;
  localparam logic [2:0] METH_OVERLAP = 3'd4;

  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam logic [5:0]  RATIO_STEPS = 6'd16;
  localparam logic [5:0]  COS_STEPS   = 6'd32;
  localparam logic [5:0]  SQRT_STEPS  = 6'd16;

endpackage

// ----- design/msim_accum.sv -----
module msim_accum (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             clr_i,
  input  logic [7:0]       e1_i,
  input  logic [7:0]       e2_i,
  output msim_pkg::totals_t totals_o
);
  import msim_pkg::*;

  totals_t tot_q, tot_d;
  logic [7:0]  lo, hi;
  logic [15:0] p12, p11, p22;

  function automatic logic [15:0] sat16(logic [15:0] acc, logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, v};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [23:0] sat24(logic [23:0] acc, logic [15:0] v);
    logic [24:0] s;
    s = {1'b0, acc} + 25'(v);
    return s[24] ? 24'hFFFFFF : s[23:0];
  endfunction

  always_comb begin
    lo  = (e1_i < e2_i) ? e1_i : e2_i;
    hi  = (e1_i < e2_i) ? e2_i : e1_i;
    p12 = e1_i * e2_i;
    p11 = e1_i * e1_i;
    p22 = e2_i * e2_i;
    tot_d = tot_q;
    if (clr_i) begin
      tot_d = '0;
    end else if (en_i) begin
      tot_d.min_total         = sat16(tot_q.min_total, {8'd0, lo});
      tot_d.max_total         = sat16(tot_q.max_total, {8'd0, hi});
      tot_d.first_total       = sat16(tot_q.first_total, {8'd0, e1_i});
      tot_d.second_total      = sat16(tot_q.second_total, {8'd0, e2_i});
      tot_d.dot_total         = sat24(tot_q.dot_total, p12);
      tot_d.first_norm_total  = sat24(tot_q.first_norm_total, p11);
      tot_d.second_norm_total = sat24(tot_q.second_norm_total, p22);
      if (((e1_i != 8'd0) != (e2_i != 8'd0)) && (tot_q.mismatch_total != 9'h1FF)) begin
        tot_d.mismatch_total = tot_q.mismatch_total + 9'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0;
    end else begin
      tot_q <= tot_d;
    end
  end

  assign totals_o = tot_q;

endmodule

// ----- design/msim_iter.sv -----
module msim_iter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  msim_pkg::iter_ctl_t ctl_i,
  input  logic [47:0]         num_i,
  input  logic [47:0]         den_i,
  output logic                done_o,
  output logic [31:0]         res_o
);
  import msim_pkg::*;

  logic        busy_q, busy_d, done_q, done_d, mode_q, mode_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [47:0] rem_q, rem_d, den_q, den_d;
  logic [31:0] quot_q, quot_d, root_q, root_d;
  logic [30:0] bit_q, bit_d;
  logic [32:0] trial;
  logic [49:0] opa, opb, diff;
  logic        ge;

  // One shared subtractor serves the restoring divide and the square root.
  always_comb begin
    trial = {1'b0, root_q} + {2'b0, bit_q};
    if (mode_q) begin
      opa = {18'd0, rem_q[31:0]};
      opb = {17'd0, trial};
    end else begin
      opa = {1'b0, rem_q, 1'b0};
      opb = {2'b0, den_q};
    end
    diff = opa - opb;
    ge   = !diff[49];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    root_d = root_q;
    bit_d  = bit_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      mode_d = ctl_i.sqrt_mode;
      cnt_d  = ctl_i.steps;
      rem_d  = num_i;
      den_d  = den_i;
      quot_d = '0;
      root_d = '0;
      bit_d  = 31'h40000000;
    end else if (busy_q) begin
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      if (mode_q) begin
        bit_d = bit_q >> 2;
        if (ge) begin
          rem_d  = {16'd0, diff[31:0]};
          root_d = (root_q >> 1) + {1'b0, bit_q};
        end else begin
          root_d = root_q >> 1;
        end
      end else begin
        if (ge) begin
          rem_d  = diff[47:0];
          quot_d = {quot_q[30:0], 1'b1};
        end else begin
          rem_d  = opa[47:0];
          quot_d = {quot_q[30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign done_o = done_q;
  assign res_o  = mode_q ? root_q : quot_q;

endmodule

// ----- design/multiset_similarity_engine.sv -----
// Similarity engine for two signatures of 8-bit exponents.
// Input channel: in_valid_i / in_stall_o carry one word pair per transfer,
// LANES exponents of each signature, with last_word marking the final pair.
// Output channel: out_valid_o / out_stall_i carry one result per signature.
// The method register is written through cfg_we_i / cfg_data_i; the user
// must write it only while idle, as the block itself does not enforce it.
// Each word is taken in S_IDLE; then one lane per cycle passes through a
// single min/max/multiply and saturating-accumulate unit in S_LANE.
// After a last word, one shared subtract unit finishes the metric: Jaccard,
// Dice, overlap and Hamming use a 16-step divide; cosine uses two multiplies
// on a shared 24x24 multiplier, a 32-step divide and a 16-step square root.
// Invalid methods and zero denominators go from S_PREP straight to S_DONE.
// Results sit in an output register; non-last words keep streaming while a
// result waits, and a new result waits until the previous transfer is taken.
// Reset clears all totals, the method register and the output valid.
module multiset_similarity_engine #(
  parameter int SIGNATURE_LENGTH = 64,
  parameter int LANES            = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  msim_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output msim_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_data_i
);
  import msim_pkg::*;

  localparam int LaneW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam logic [8:0] SigLen = 9'(SIGNATURE_LENGTH);

  typedef enum logic [3:0] {
    S_IDLE, S_LANE, S_PREP, S_MULA, S_MULB, S_CHK, S_DIV, S_SQRT, S_DONE
  } state_e;

  state_e      state_q, state_d;
  logic [63:0] a_q, a_d, b_q, b_d;
  logic        last_q, last_d, cos_q, cos_d;
  logic [LaneW-1:0] lane_q, lane_d;
  logic [47:0] num_q, num_d, den_q, den_d;
  logic [2:0]  method_q, method_d;
  out_item_t   res_q, res_d, out_item_q, out_item_d;
  logic        out_valid_q, out_valid_d;
  logic        acc_en, acc_clr, iter_done;
  logic [23:0] mul_a, mul_b;
  logic [47:0] product, iter_num;
  logic [31:0] iter_res;
  logic [16:0] dice_den;
  logic [15:0] ovl_den;
  iter_ctl_t   iter_ctl;
  totals_t     tot;

  msim_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (acc_en),
    .clr_i    (acc_clr),
    .e1_i     (a_q[7:0]),
    .e2_i     (b_q[7:0]),
    .totals_o (tot)
  );

  msim_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (iter_ctl),
    .num_i  (iter_num),
    .den_i  (den_q),
    .done_o (iter_done),
    .res_o  (iter_res)
  );

  assign mul_a    = (state_q == S_MULA) ? tot.dot_total : tot.first_norm_total;
  assign mul_b    = (state_q == S_MULA) ? tot.dot_total : tot.second_norm_total;
  assign product  = mul_a * mul_b;
  assign iter_num = (state_q == S_DIV) ? {16'd0, iter_res} : num_q;
  assign dice_den = {1'b0, tot.first_total} + {1'b0, tot.second_total};
  assign ovl_den  = (tot.first_total < tot.second_total) ? tot.first_total
                                                          : tot.second_total;

  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    last_d      = last_q;
    cos_d       = cos_q;
    lane_d      = lane_q;
    num_d       = num_q;
    den_d       = den_q;
    res_d       = res_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    method_d    = cfg_we_i ? cfg_data_i : method_q;
    acc_en      = 1'b0;
    acc_clr     = 1'b0;
    iter_ctl    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          a_d     = in_item_i.first_word;
          b_d     = in_item_i.second_word;
          last_d  = in_item_i.last_word;
          lane_d  = '0;
          state_d = S_LANE;
        end
      end
      S_LANE: begin
        acc_en = 1'b1;
        a_d    = a_q >> 8;
        b_d    = b_q >> 8;
        if (lane_q == LaneW'(LANES - 1)) begin
          state_d = last_q ? S_PREP : S_IDLE;
        end else begin
          lane_d = lane_q + LaneW'(1);
        end
      end
      S_PREP: begin
        res_d = '0;
        res_d.hamming_distance = tot.mismatch_total;
        cos_d   = 1'b0;
        state_d = S_CHK;
        unique case (method_q)
          METH_JACCARD: begin
            num_d = 48'(tot.min_total);
            den_d = 48'(tot.max_total);
            if (tot.max_total == 16'd0) begin
              res_d.empty_denominator = 1'b1;
              state_d = S_DONE;
            end
          end
          METH_COSINE: begin
            cos_d   = 1'b1;
            state_d = S_MULA;
            if (tot.first_norm_total == 24'd0 || tot.second_norm_total == 24'd0) begin
              res_d.empty_denominator = 1'b1;
              state_d = S_DONE;
            end
          end
          METH_HAMMING: begin
            num_d = 48'(SigLen - tot.mismatch_total);
            den_d = 48'(SigLen);
            if (tot.mismatch_total >= SigLen) begin
              state_d = S_DONE;
            end
          end
          METH_DICE: begin
            num_d = 48'({tot.min_total, 1'b0});
            den_d = 48'(dice_den);
            if (dice_den == 17'd0) begin
              res_d.empty_denominator = 1'b1;
              state_d = S_DONE;
            end
          end
          METH_OVERLAP: begin
            num_d = 48'(tot.min_total);
            den_d = 48'(ovl_den);
            if (ovl_den == 16'd0) begin
              res_d.empty_denominator = 1'b1;
              state_d = S_DONE;
            end
          end
          default: begin
            res_d.bad_method = 1'b1;
            state_d = S_DONE;
          end
        endcase
      end
      S_MULA: begin
        num_d   = product;
        state_d = S_MULB;
      end
      S_MULB: begin
        den_d   = product;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (num_q >= den_q) begin
          res_d.similarity_q16 = ONE_Q16;
          state_d = S_DONE;
        end else begin
          iter_ctl.start = 1'b1;
          iter_ctl.steps = cos_q ? COS_STEPS : RATIO_STEPS;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (iter_done) begin
          if (cos_q) begin
            iter_ctl.start     = 1'b1;
            iter_ctl.sqrt_mode = 1'b1;
            iter_ctl.steps     = SQRT_STEPS;
            state_d = S_SQRT;
          end else begin
            res_d.similarity_q16 = {1'b0, iter_res[15:0]};
            state_d = S_DONE;
          end
        end
      end
      S_SQRT: begin
        if (iter_done) begin
          res_d.similarity_q16 = iter_res[16:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_item_d  = res_q;
          out_valid_d = 1'b1;
          acc_clr     = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      method_q    <= METH_JACCARD;
      lane_q      <= '0;
      last_q      <= 1'b0;
      cos_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      method_q    <= method_d;
      lane_q      <= lane_d;
      last_q      <= last_d;
      cos_q       <= cos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    num_q      <= num_d;
    den_q      <= den_d;
    res_q      <= res_d;
    out_item_q <= out_item_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- design/msim_checker.sv -----
`include "multiset_similarity_engine_defines.svh"

module msim_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input msim_pkg::out_item_t out_item_o
);
  import msim_pkg::*;

  `MSE_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o), "Stalled result changed.")
  `MSE_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o, "Result valid during reset.")
  `MSE_ASSERT(a_flags_excl, clk_i, rst_ni, out_valid_o |-> !(out_item_o.empty_denominator && out_item_o.bad_method), "Both error flags set.")
  `MSE_ASSERT(a_flag_zero, clk_i, rst_ni, out_valid_o && (out_item_o.empty_denominator || out_item_o.bad_method) |-> out_item_o.similarity_q16 == 17'd0, "Flagged result is not zero.")
  `MSE_ASSERT(a_sim_range, clk_i, rst_ni, out_valid_o |-> out_item_o.similarity_q16 <= ONE_Q16, "Similarity above one.")

endmodule

bind multiset_similarity_engine msim_checker u_msim_checker (.*);

// ----- sim/multiset_similarity_engine_tb.sv -----
`timescale 1ns / 100ps

module multiset_similarity_engine_tb;
  import msim_pkg::*;

  localparam int SIG_LEN = 64;
  localparam int LANE_COUNT = 8;
  localparam logic [2:0] METH_BAD_LOW = 3'd5;
  localparam logic [2:0] METH_BAD_HIGH = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_data_i = '0;

  multiset_similarity_engine #(.SIGNATURE_LENGTH(SIG_LEN), .LANES(LANE_COUNT)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  in_item_t word_queue[$];
  out_item_t expected_results[$];
  logic [2:0] method_shadow;
  totals_t sums;
  int error_count = 0;
  int words_sent = 0;
  int results_seen = 0;
  int hold_cycles = 0;
  logic driver_on = 1'b0;
  logic in_taken = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
    error_count++;
  endtask

  function automatic logic [31:0] capped_sum(input logic [31:0] acc, input logic [31:0] v,
                                             input logic [31:0] cap);
    logic [32:0] s;
    s = acc + v;
    return (s > cap) ? cap : s[31:0];
  endfunction

  function automatic logic [16:0] q16_ratio(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    if (num >= den) return ONE_Q16;
    q = (num << 16) / den;
    return (q > 64'h10000) ? ONE_Q16 : q[16:0];
  endfunction

  function automatic logic [16:0] cosine_q16(input totals_t t);
    logic [63:0] n, d, q, r, part;
    n = t.dot_total * t.dot_total;
    d = t.first_norm_total * t.second_norm_total;
    if (n >= d) return ONE_Q16;
    part = n;
    q = 0;
    for (int i = 0; i < 32; i++) begin
      part = part << 1;
      q = q << 1;
      if (part >= d) begin
        part = part - d;
        q = q | 64'd1;
      end
    end
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= q) r = r | (64'd1 << b);
    end
    return r[16:0];
  endfunction

  function automatic void clear_sums();
    sums = '0;
  endfunction

  // Accumulates one word and queues a result when it closes a signature.
  function automatic void predict_word(input in_item_t w);
    logic [31:0] e1, e2, den;
    out_item_t res;
    for (int k = 0; k < LANE_COUNT; k++) begin
      e1 = w.first_word[8*k +: 8];
      e2 = w.second_word[8*k +: 8];
      sums.min_total = 16'(capped_sum(sums.min_total, (e1 < e2) ? e1 : e2, 32'hFFFF));
      sums.max_total = 16'(capped_sum(sums.max_total, (e1 > e2) ? e1 : e2, 32'hFFFF));
      sums.first_total = 16'(capped_sum(sums.first_total, e1, 32'hFFFF));
      sums.second_total = 16'(capped_sum(sums.second_total, e2, 32'hFFFF));
      sums.dot_total = 24'(capped_sum(sums.dot_total, e1 * e2, 32'hFFFFFF));
      sums.first_norm_total = 24'(capped_sum(sums.first_norm_total, e1 * e1, 32'hFFFFFF));
      sums.second_norm_total = 24'(capped_sum(sums.second_norm_total, e2 * e2, 32'hFFFFFF));
      if ((e1 != 0) != (e2 != 0))
        sums.mismatch_total = 9'(capped_sum(sums.mismatch_total, 1, 32'h1FF));
    end
    if (!w.last_word) return;
    res = '0;
    res.hamming_distance = sums.mismatch_total;
    case (method_shadow)
      METH_JACCARD: begin
        if (sums.max_total == 0) res.empty_denominator = 1'b1;
        else res.similarity_q16 = q16_ratio(sums.min_total, sums.max_total);
      end
      METH_COSINE: begin
        if (sums.first_norm_total == 0 || sums.second_norm_total == 0)
          res.empty_denominator = 1'b1;
        else res.similarity_q16 = cosine_q16(sums);
      end
      METH_HAMMING: begin
        if (sums.mismatch_total < SIG_LEN)
          res.similarity_q16 = q16_ratio(SIG_LEN - sums.mismatch_total, SIG_LEN);
      end
      METH_DICE: begin
        den = sums.first_total + sums.second_total;
        if (den == 0) res.empty_denominator = 1'b1;
        else res.similarity_q16 = q16_ratio(2 * sums.min_total, den);
      end
      METH_OVERLAP: begin
        den = (sums.first_total < sums.second_total) ? sums.first_total : sums.second_total;
        if (den == 0) res.empty_denominator = 1'b1;
        else res.similarity_q16 = q16_ratio(sums.min_total, den);
      end
      default: res.bad_method = 1'b1;
    endcase
    expected_results.push_back(res);
    clear_sums();
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] random_exponents(input int style);
    logic [63:0] v;
    v = {$urandom, $urandom};
    for (int k = 0; k < 8; k++) begin
      case (style)
        0: if ($urandom_range(0, 2) == 0) v[8*k +: 8] = 8'd0;
        1: v[8*k +: 8] = v[8*k +: 8] & 8'h0F;
        default: ;
      endcase
    end
    return v;
  endfunction

  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
  end

  int send_gap = 0;
  always @(negedge clk_i) begin
    if (driver_on) begin
      if (in_taken) begin
        predict_word(in_item_i);
        words_sent++;
        send_gap = gap_length();
      end
      if (!in_valid_i || in_taken) begin
        if (send_gap > 0 || word_queue.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid_i <= 1'b0;
        end else begin
          in_item_i <= word_queue.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  int recv_gap = 0;
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall_i <= 1'b1;
    end else begin
      recv_gap = gap_length();
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_item_o.similarity_q16 !== want.similarity_q16)
          report_mismatch("similarity_q16", out_item_o.similarity_q16, want.similarity_q16);
        if (out_item_o.hamming_distance !== want.hamming_distance)
          report_mismatch("hamming_distance", out_item_o.hamming_distance,
                          want.hamming_distance);
        if (out_item_o.empty_denominator !== want.empty_denominator)
          report_mismatch("empty_denominator", out_item_o.empty_denominator,
                          want.empty_denominator);
        if (out_item_o.bad_method !== want.bad_method)
          report_mismatch("bad_method", out_item_o.bad_method, want.bad_method);
      end
    end
  end

  task automatic push_word(input logic [63:0] a, input logic [63:0] b, input logic l);
    in_item_t w;
    w.first_word = a;
    w.second_word = b;
    w.last_word = l;
    word_queue.push_back(w);
  endtask

  task automatic push_signature(input int style, input int words);
    for (int i = 0; i < words; i++)
      push_word(random_exponents(style), random_exponents(style), i == words - 1);
  endtask

  task automatic drain();
    while (word_queue.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_method(input logic [2:0] m);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    method_shadow = m;
  endtask

  initial begin
    logic [2:0] m;
    method_shadow = METH_JACCARD;
    clear_sums();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    driver_on = 1'b1;

    // Directed words under the reset method, then every method with edge data.
    push_word('0, '0, 1'b1);
    push_word('1, '1, 1'b1);
    push_word('1, '0, 1'b1);
    push_word(64'h0102030405060708, 64'h0807060504030201, 1'b1);
    drain();
    for (int mi = 0; mi <= 7; mi++) begin
      write_method(mi[2:0]);
      push_word('0, '0, 1'b1);
      push_word('1, '1, 1'b0);
      push_word(64'h00FF00FF00FF00FF, 64'hFF00FF0000FF00FF, 1'b1);
      drain();
    end

    // Overlong signature saturates every total.
    write_method(METH_COSINE);
    for (int i = 0; i < 300; i++) push_word('1, (i % 2) ? '1 : 64'h01, i == 299);
    drain();

    // Output held off while words keep arriving, so the input backs up.
    write_method(METH_HAMMING);
    hold_cycles = 400;
    for (int s = 0; s < 12; s++) push_signature(0, 2);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: m = METH_JACCARD;
        1: m = METH_BAD_HIGH;
        2: m = METH_COSINE;
        3: m = METH_HAMMING;
        4: m = METH_DICE;
        5: m = METH_OVERLAP;
        6: m = METH_BAD_LOW;
        default: m = 3'($urandom_range(0, 4));
      endcase
      write_method(m);
      for (int s = 0; s < 20; s++) begin
        if ($urandom_range(0, 19) == 0) push_word('0, random_exponents(2), 1'b1);
        else push_signature($urandom_range(0, 2), $urandom_range(1, 8));
      end
      drain();
    end

    $display("Covered %0d words and %0d results over all eight method settings,", words_sent,
             results_seen);
    $display("including saturated totals, empty signatures and a long output hold-off.");
    if (error_count == 0) begin
      $display("multiset_similarity_engine_tb OK");
    end else begin
      $display("multiset_similarity_engine_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("multiset_similarity_engine_tb NOT OK");
    $finish;
  end

endmodule
